// ===== sv/slrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slrc_pkg;

    localparam int DUTY_W    = 14;
    localparam int ANGLE_W   = 7;
    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 3;

    localparam int DEFAULT_MAX_ANGLE = 90;

    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ZERO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_NINETY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL        = 3'd6;

    localparam logic [DUTY_W-1:0] RST_DUTY_ZERO   = 14'd1240;
    localparam logic [DUTY_W-1:0] RST_DUTY_NINETY = 14'd2120;
    localparam logic [TICK_W-1:0] RST_UP_STEP     = 10'd15;
    localparam logic [TICK_W-1:0] RST_DOWN_STEP   = 10'd20;
    localparam logic [TICK_W-1:0] RST_DEBOUNCE    = 10'd120;
    localparam logic [TICK_W-1:0] RST_POLL        = 10'd250;

    typedef struct packed {
        logic button_edge;
        logic auto_open;
    } tick_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [ANGLE_W-1:0] angle_now;
        logic               moving;
        logic               lid_open;
        logic               manual_mode;
        logic               closed_report;
    } result_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_at_zero;
        logic [DUTY_W-1:0] duty_at_ninety;
        logic              open_at_zero;
        logic [TICK_W-1:0] up_step_ticks;
        logic [TICK_W-1:0] down_step_ticks;
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] poll_ticks;
    } config_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] target;
        logic               move_active;
        logic               move_up;
        logic [TICK_W-1:0]  step_timer;
        logic               manual_flag;
        logic               stored_open;
        logic               open_status;
        logic [TICK_W-1:0]  since_press;
        logic               last_auto;
        logic [TICK_W-1:0]  poll_timer;
        logic               auto_closing;
    } lid_state_t;

endpackage

`default_nettype wire

// ===== sv/servo_lid_ramp_controller_unit.sv =====
// Servo lid ramp controller. Each tick word is one millisecond tick and yields exactly one
// result word. The block accepts a tick word every clock cycle as long as the result side
// is not stalled. A result word comes out behind three register stages: the state update
// stage, the angle-times-span multiply stage and the reciprocal-multiply stage that scales the
// duty. The configuration port is always ready and must only be written while no result is
// outstanding; writing the open_at_zero register cancels any move and parks the lid at the new
// closed angle.
`timescale 1ns / 1ps
`default_nettype none

module servo_lid_ramp_controller_unit #(
    parameter int MAX_ANGLE = slrc_pkg::DEFAULT_MAX_ANGLE
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   tick_valid,
    output logic                                  tick_stall,
    input  slrc_pkg::tick_word_t                  tick_word,
    output logic                                  result_valid,
    input  wire                                   result_stall,
    output slrc_pkg::result_word_t                result_word,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [slrc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [slrc_pkg::DUTY_W-1:0]           cfg_data
);
    import slrc_pkg::*;

    localparam int PROD_W  = DUTY_W + ANGLE_W;
    localparam int SHIFT   = PROD_W + $clog2(MAX_ANGLE);
    localparam int SCALE_W = 2 * PROD_W + 1;
    localparam logic [PROD_W:0] Recip =
        (PROD_W+1)'((((64'd1 << SHIFT) + 64'(MAX_ANGLE)) - 64'd1) / 64'(MAX_ANGLE));
    localparam logic [ANGLE_W-1:0] MaxAngle = ANGLE_W'(MAX_ANGLE);

    config_t      cfg_reg;
    lid_state_t   state_reg;
    lid_state_t   state_next;
    logic         report_next;

    logic         a_valid_reg;
    logic         b_valid_reg;
    logic         result_valid_reg;
    result_word_t a_word_reg;
    result_word_t b_word_reg;
    result_word_t result_word_reg;
    logic [PROD_W-1:0] prod_reg;

    logic               advance;
    logic               accept;
    logic               cfg_write;
    logic [ANGLE_W-1:0] open_a;
    logic [ANGLE_W-1:0] closed_a;
    logic               duty_falls;
    logic [DUTY_W-1:0]  duty_span;
    logic [ANGLE_W-1:0] angle_clamped;
    logic [SCALE_W-1:0] scaled;
    logic [DUTY_W-1:0]  quotient;
    logic [DUTY_W-1:0]  duty_next;

    function automatic lid_state_t begin_move(
        input lid_state_t         s,
        input logic [ANGLE_W-1:0] t,
        input logic               is_auto_close,
        input logic [ANGLE_W-1:0] open_angle,
        input logic [TICK_W-1:0]  up_ticks,
        input logic [TICK_W-1:0]  down_ticks
    );
        lid_state_t r;
        r = s;
        r.target = t;
        r.auto_closing = is_auto_close;
        if (s.angle == t) begin
            r.open_status = (t == open_angle);
            r.auto_closing = 1'b0;
        end else begin
            r.move_active = 1'b1;
            r.move_up = (t > s.angle);
            r.step_timer = (t > s.angle) ? up_ticks : down_ticks;
        end
        return r;
    endfunction

    assign advance    = !(result_valid_reg && result_stall);
    assign tick_stall = !advance;
    assign accept     = tick_valid && advance;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;

    assign open_a   = cfg_reg.open_at_zero ? '0 : MaxAngle;
    assign closed_a = cfg_reg.open_at_zero ? MaxAngle : '0;

    always_comb
    begin
        lid_state_t s;
        logic       press_ok;
        logic [ANGLE_W-1:0] t;
        s = state_reg;
        report_next = 1'b0;
        t = '0;

        if (s.move_active)
        begin
            if (s.step_timer != '0)
            begin
                s.step_timer = s.step_timer - 1'b1;
            end
            if (s.step_timer == '0)
            begin
                if (s.angle == s.target)
                begin
                    s.move_active = 1'b0;
                    s.open_status = (s.target == open_a);
                    report_next = s.auto_closing;
                    s.auto_closing = 1'b0;
                end else begin
                    s.angle = s.move_up ? s.angle + 1'b1 : s.angle - 1'b1;
                    s.step_timer = s.move_up ? cfg_reg.up_step_ticks
                                             : cfg_reg.down_step_ticks;
                end
            end
        end

        press_ok = tick_word.button_edge && !s.move_active &&
                   (s.since_press >= cfg_reg.debounce_ticks);
        if (press_ok)
        begin
            s.since_press = '0;
            if (!s.manual_flag)
            begin
                s.stored_open = s.open_status;
                s.manual_flag = 1'b1;
                t = s.open_status ? closed_a : open_a;
            end else begin
                s.manual_flag = 1'b0;
                t = s.stored_open ? open_a : closed_a;
            end
            s = begin_move(s, t, 1'b0, open_a, cfg_reg.up_step_ticks,
                           cfg_reg.down_step_ticks);
        end else if (!(&s.since_press))
        begin
            s.since_press = s.since_press + 1'b1;
        end

        if (s.poll_timer == '0)
        begin
            s.poll_timer = (cfg_reg.poll_ticks == '0) ? '0 : cfg_reg.poll_ticks - 1'b1;
            if (!s.manual_flag && !s.move_active && (tick_word.auto_open != s.last_auto))
            begin
                s.last_auto = tick_word.auto_open;
                t = tick_word.auto_open ? open_a : closed_a;
                if (!tick_word.auto_open && (s.angle == t))
                begin
                    report_next = 1'b1;
                end
                s = begin_move(s, t, !tick_word.auto_open, open_a,
                               cfg_reg.up_step_ticks, cfg_reg.down_step_ticks);
            end
        end else begin
            s.poll_timer = s.poll_timer - 1'b1;
        end

        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_at_zero    <= RST_DUTY_ZERO;
            cfg_reg.duty_at_ninety  <= RST_DUTY_NINETY;
            cfg_reg.open_at_zero    <= 1'b0;
            cfg_reg.up_step_ticks   <= RST_UP_STEP;
            cfg_reg.down_step_ticks <= RST_DOWN_STEP;
            cfg_reg.debounce_ticks  <= RST_DEBOUNCE;
            cfg_reg.poll_ticks      <= RST_POLL;
            state_reg               <= '0;
            a_valid_reg             <= 1'b0;
            b_valid_reg             <= 1'b0;
            result_valid_reg        <= 1'b0;
        end else begin
            if (advance)
            begin
                a_valid_reg      <= accept;
                b_valid_reg      <= a_valid_reg;
                result_valid_reg <= b_valid_reg;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DUTY_ZERO:   cfg_reg.duty_at_zero    <= cfg_data;
                    CFG_DUTY_NINETY: cfg_reg.duty_at_ninety  <= cfg_data;
                    CFG_OPEN_ZERO:
                    begin
                        cfg_reg.open_at_zero   <= cfg_data[0];
                        state_reg.move_active  <= 1'b0;
                        state_reg.angle        <= cfg_data[0] ? MaxAngle : '0;
                        state_reg.target       <= cfg_data[0] ? MaxAngle : '0;
                        state_reg.step_timer   <= '0;
                        state_reg.open_status  <= 1'b0;
                        state_reg.auto_closing <= 1'b0;
                    end
                    CFG_UP_STEP:     cfg_reg.up_step_ticks   <= cfg_data[TICK_W-1:0];
                    CFG_DOWN_STEP:   cfg_reg.down_step_ticks <= cfg_data[TICK_W-1:0];
                    CFG_DEBOUNCE:    cfg_reg.debounce_ticks  <= cfg_data[TICK_W-1:0];
                    CFG_POLL:        cfg_reg.poll_ticks      <= cfg_data[TICK_W-1:0];
                    default:         ;
                endcase
            end else if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    assign duty_falls    = cfg_reg.duty_at_ninety < cfg_reg.duty_at_zero;
    assign duty_span     = duty_falls ? cfg_reg.duty_at_zero - cfg_reg.duty_at_ninety
                                      : cfg_reg.duty_at_ninety - cfg_reg.duty_at_zero;
    assign angle_clamped = (a_word_reg.angle_now > MaxAngle) ? MaxAngle
                                                             : a_word_reg.angle_now;
    assign scaled        = SCALE_W'(prod_reg) * SCALE_W'(Recip);
    assign quotient      = DUTY_W'(scaled >> SHIFT);
    assign duty_next     = duty_falls ? cfg_reg.duty_at_zero - quotient
                                      : cfg_reg.duty_at_zero + quotient;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_word_reg.duty               <= '0;
            a_word_reg.angle_now          <= state_next.angle;
            a_word_reg.moving             <= state_next.move_active;
            a_word_reg.lid_open           <= state_next.open_status;
            a_word_reg.manual_mode        <= state_next.manual_flag;
            a_word_reg.closed_report      <= report_next;
            prod_reg                      <= PROD_W'(duty_span) * PROD_W'(angle_clamped);
            b_word_reg                    <= a_word_reg;
            result_word_reg.duty          <= duty_next;
            result_word_reg.angle_now     <= b_word_reg.angle_now;
            result_word_reg.moving        <= b_word_reg.moving;
            result_word_reg.lid_open      <= b_word_reg.lid_open;
            result_word_reg.manual_mode   <= b_word_reg.manual_mode;
            result_word_reg.closed_report <= b_word_reg.closed_report;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.angle <= MaxAngle)
        else $error("Lid angle left its range.");

    a_target_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.target == '0) || (state_reg.target == MaxAngle))
        else $error("Move target is neither endpoint.");

    a_report_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_word_reg.closed_report) |->
        !result_word_reg.lid_open)
        else $error("Close report while the lid reads open.");

    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid_reg) |-> $past(!result_stall))
        else $error("Result word dropped while stalled.");

endmodule

`default_nettype wire

// ===== bench/tb_servo_lid_ramp_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_servo_lid_ramp_controller_unit;

    import slrc_pkg::*;

    class lid_ramp_ledger;
        config_t regs;
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] target;
        logic [TICK_W-1:0] step_left;
        logic [TICK_W-1:0] since_press;
        logic [TICK_W-1:0] poll_left;
        bit moving;
        bit rising;
        bit manual;
        bit stored_open;
        bit open_status;
        bit last_auto;
        bit auto_closing;
        result_word_t due[$];
        int checked;
        int mismatches;
        int moves_done;
        int close_reports;
        int presses;

        function new();
            regs.duty_at_zero = RST_DUTY_ZERO;
            regs.duty_at_ninety = RST_DUTY_NINETY;
            regs.open_at_zero = 1'b0;
            regs.up_step_ticks = RST_UP_STEP;
            regs.down_step_ticks = RST_DOWN_STEP;
            regs.debounce_ticks = RST_DEBOUNCE;
            regs.poll_ticks = RST_POLL;
            angle = '0;
            target = '0;
            step_left = '0;
            since_press = '0;
            poll_left = '0;
        endfunction

        function logic [ANGLE_W-1:0] open_angle();
            return regs.open_at_zero ? '0 : ANGLE_W'(DEFAULT_MAX_ANGLE);
        endfunction

        function logic [ANGLE_W-1:0] closed_angle();
            return regs.open_at_zero ? ANGLE_W'(DEFAULT_MAX_ANGLE) : '0;
        endfunction

        function logic [DUTY_W-1:0] duty_of(logic [ANGLE_W-1:0] a_in);
            int unsigned d0;
            int unsigned d1;
            int unsigned a;
            d0 = regs.duty_at_zero;
            d1 = regs.duty_at_ninety;
            a = (a_in > DEFAULT_MAX_ANGLE) ? DEFAULT_MAX_ANGLE : a_in;
            if (d1 >= d0)
            begin
                return DUTY_W'(d0 + (d1 - d0) * a / DEFAULT_MAX_ANGLE);
            end
            return DUTY_W'(d0 - (d0 - d1) * a / DEFAULT_MAX_ANGLE);
        endfunction

        // Returns 1 when an automatic close finds the lid already closed.
        function bit start_move(logic [ANGLE_W-1:0] t, bit auto_close);
            if (t > DEFAULT_MAX_ANGLE)
            begin
                t = ANGLE_W'(DEFAULT_MAX_ANGLE);
            end
            target = t;
            auto_closing = auto_close;
            if (angle == t)
            begin
                open_status = (t == open_angle());
                auto_closing = 1'b0;
                return auto_close;
            end
            moving = 1'b1;
            rising = t > angle;
            step_left = rising ? regs.up_step_ticks : regs.down_step_ticks;
            return 1'b0;
        endfunction

        function void take_config(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
            case (idx)
                CFG_DUTY_ZERO: regs.duty_at_zero = data;
                CFG_DUTY_NINETY: regs.duty_at_ninety = data;
                CFG_OPEN_ZERO:
                begin
                    regs.open_at_zero = data[0];
                    moving = 1'b0;
                    angle = closed_angle();
                    target = angle;
                    step_left = '0;
                    open_status = 1'b0;
                    auto_closing = 1'b0;
                end
                CFG_UP_STEP: regs.up_step_ticks = data[TICK_W-1:0];
                CFG_DOWN_STEP: regs.down_step_ticks = data[TICK_W-1:0];
                CFG_DEBOUNCE: regs.debounce_ticks = data[TICK_W-1:0];
                CFG_POLL: regs.poll_ticks = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_tick(tick_word_t w);
            result_word_t r;
            bit report;
            bit taken;
            report = 1'b0;
            if (moving)
            begin
                if (step_left != 0)
                begin
                    step_left--;
                end
                if (step_left == 0)
                begin
                    if (angle == target)
                    begin
                        moving = 1'b0;
                        open_status = (target == open_angle());
                        report = auto_closing;
                        auto_closing = 1'b0;
                        moves_done++;
                    end
                    else
                    begin
                        angle = rising ? angle + 7'd1 : angle - 7'd1;
                        step_left = rising ? regs.up_step_ticks : regs.down_step_ticks;
                    end
                end
            end

            taken = w.button_edge && !moving && since_press >= regs.debounce_ticks;
            if (taken)
            begin
                since_press = '0;
                presses++;
                if (!manual)
                begin
                    stored_open = open_status;
                    manual = 1'b1;
                    void'(start_move(open_status ? closed_angle() : open_angle(), 1'b0));
                end
                else
                begin
                    manual = 1'b0;
                    void'(start_move(stored_open ? open_angle() : closed_angle(), 1'b0));
                end
            end
            else if (since_press != '1)
            begin
                since_press++;
            end

            if (poll_left == 0)
            begin
                poll_left = (regs.poll_ticks == 0) ? '0 : regs.poll_ticks - 10'd1;
                if (!manual && !moving && w.auto_open != last_auto)
                begin
                    last_auto = w.auto_open;
                    if (w.auto_open)
                    begin
                        void'(start_move(open_angle(), 1'b0));
                    end
                    else if (start_move(closed_angle(), 1'b1))
                    begin
                        report = 1'b1;
                    end
                end
            end
            else
            begin
                poll_left--;
            end

            if (report)
            begin
                close_reports++;
            end
            r.duty = duty_of(angle);
            r.angle_now = angle;
            r.moving = moving;
            r.lid_open = open_status;
            r.manual_mode = manual;
            r.closed_report = report;
            due.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("ERROR %s", msg);
            end
            else if (mismatches == 41)
            begin
                $display("ERROR further mismatch lines suppressed");
            end
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (due.size() == 0)
            begin
                flag($sformatf("result word with no tick pending: angle %0d, duty %0d",
                               got.angle_now, got.duty));
                return;
            end
            want = due.pop_front();
            checked++;
            if (got.duty !== want.duty)
            begin
                flag($sformatf("word %0d duty: got %0d, want %0d", checked, got.duty,
                               want.duty));
            end
            if (got.angle_now !== want.angle_now)
            begin
                flag($sformatf("word %0d angle_now: got %0d, want %0d", checked,
                               got.angle_now, want.angle_now));
            end
            if (got.moving !== want.moving)
            begin
                flag($sformatf("word %0d moving: got %0d, want %0d", checked,
                               got.moving, want.moving));
            end
            if (got.lid_open !== want.lid_open)
            begin
                flag($sformatf("word %0d lid_open: got %0d, want %0d", checked,
                               got.lid_open, want.lid_open));
            end
            if (got.manual_mode !== want.manual_mode)
            begin
                flag($sformatf("word %0d manual_mode: got %0d, want %0d", checked,
                               got.manual_mode, want.manual_mode));
            end
            if (got.closed_report !== want.closed_report)
            begin
                flag($sformatf("word %0d closed_report: got %0d, want %0d", checked,
                               got.closed_report, want.closed_report));
            end
        endfunction
    endclass

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tick_valid = 1'b0;
    logic tick_stall;
    tick_word_t tick_word = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_word_t result_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUTY_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int ticks_sent = 0;
    int settings_applied = 0;

    lid_ramp_ledger ledger = new;

    servo_lid_ramp_controller_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .tick_valid(tick_valid),
        .tick_stall(tick_stall),
        .tick_word(tick_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_word(result_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            ledger.check_word(result_word);
        end
    end

    task automatic send_tick(input logic btn, input logic cmd);
        tick_word_t w;
        w.button_edge = btn;
        w.auto_open = cmd;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_word <= w;
        @(posedge clk);
        while (tick_stall)
        begin
            @(posedge clk);
        end
        ledger.take_tick(w);
        ticks_sent++;
    endtask

    task automatic drain_results();
        tick_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (ledger.due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        ledger.take_config(idx, data);
    endtask

    task automatic apply_settings(input config_t s);
        write_reg(CFG_SPARE, DUTY_W'($urandom));
        write_reg(CFG_DUTY_ZERO, s.duty_at_zero);
        write_reg(CFG_DUTY_NINETY, s.duty_at_ninety);
        write_reg(CFG_OPEN_ZERO, {13'($urandom), s.open_at_zero});
        write_reg(CFG_UP_STEP, {4'($urandom), s.up_step_ticks});
        write_reg(CFG_DOWN_STEP, {4'($urandom), s.down_step_ticks});
        write_reg(CFG_DEBOUNCE, {4'($urandom), s.debounce_ticks});
        write_reg(CFG_POLL, {4'($urandom), s.poll_ticks});
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return DUTY_W'($urandom);
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_delay();
        if ($urandom_range(9) == 0)
        begin
            return TICK_W'($urandom_range(4, 12));
        end
        return TICK_W'($urandom_range(0, 2));
    endfunction

    function automatic config_t pick_settings(input int phase);
        config_t s;
        s.duty_at_zero = pick_duty();
        s.duty_at_ninety = pick_duty();
        s.open_at_zero = 1'($urandom_range(1));
        s.up_step_ticks = pick_delay();
        s.down_step_ticks = pick_delay();
        s.debounce_ticks = ($urandom_range(9) == 0) ? '1 : TICK_W'($urandom_range(0, 40));
        s.poll_ticks = TICK_W'($urandom_range(0, 12));
        if (phase == 1)
        begin
            s = '{duty_at_zero: '0, duty_at_ninety: 14'h3FFF, open_at_zero: 1'b0,
                  up_step_ticks: '0, down_step_ticks: '0, debounce_ticks: '0,
                  poll_ticks: '0};
        end
        else if (phase == PHASES - 1)
        begin
            s = '{duty_at_zero: 14'h3FFF, duty_at_ninety: '0, open_at_zero: 1'b1,
                  up_step_ticks: '1, down_step_ticks: '1, debounce_ticks: '1,
                  poll_ticks: '1};
        end
        return s;
    endfunction

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((tick_valid && !tick_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("servo_lid_ramp_controller_unit: mismatch");
        $finish;
    end

    initial
    begin
        config_t s;
        bit level;
        int items;
        level = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After the second register load the lid is parked at the closed angle while the last
        // sampled command is still open, so the next closing command completes at once.
        s = '{duty_at_zero: 14'h3FFF, duty_at_ninety: '0, open_at_zero: 1'b0,
              up_step_ticks: '0, down_step_ticks: '0, debounce_ticks: 10'd2,
              poll_ticks: '0};
        apply_settings(s);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        drain_results();
        s.open_at_zero = 1'b1;
        apply_settings(s);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct = 26;
                    stall_pct = 26;
                end
            endcase
            apply_settings(pick_settings(p));
            items = (p == PHASES - 1) ? 40 : 170;
            for (int i = 0; i < items; i++)
            begin
                if (i == items / 2)
                begin
                    drain_results();
                end
                if ($urandom_range(39) == 0)
                begin
                    level = !level;
                end
                send_tick($urandom_range(11) == 0, level);
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d tick words under %0d register settings, idling and stalling both sides.",
                 ticks_sent, settings_applied);
        $display("Checked %0d result words: %0d finished moves, %0d close reports, %0d presses.",
                 ledger.checked, ledger.moves_done, ledger.close_reports, ledger.presses);
        if (ledger.mismatches == 0 && ledger.due.size() == 0)
        begin
            $display("servo_lid_ramp_controller_unit: match");
        end
        else
        begin
            $display("servo_lid_ramp_controller_unit: mismatch");
        end
        $finish;
    end

endmodule
